// ===== rtl/tq_pkg.sv =====
// package: shared constants and codes for the team queue
package tq_pkg;

    // default sizing
    localparam int CAPACITY_DEF = 1024;
    localparam int GROUPS_DEF   = 256;

    // fixed field widths
    localparam int OPC_W = 1;
    localparam int GID_W = 8;
    localparam int SN_W  = 11;
    localparam int LIM_W = 11;

    // apb port sizing
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // opcodes
    localparam logic [OPC_W-1:0] OP_ENQ = 1'b0;
    localparam logic [OPC_W-1:0] OP_DEQ = 1'b1;

    // register map, indexed by paddr[2]
    localparam logic [0:0] REG_ARRIVAL_LIMIT = 1'b0;

    // reset value of the arrival limit
    localparam logic [LIM_W-1:0] LIMIT_RST = 11'd1024;

endpackage

// ===== rtl/tq_if.sv =====
// interfaces: request and response channels of the team queue

interface tq_in_if;
    logic                       valid;
    logic                       ready;
    logic [tq_pkg::OPC_W-1:0]   opcode;
    logic [tq_pkg::GID_W-1:0]   group_id;

    modport source (output valid, output opcode, output group_id, input ready);
    modport sink   (input valid, input opcode, input group_id, output ready);
endinterface

interface tq_out_if;
    logic                       valid;
    logic                       ready;
    logic [tq_pkg::SN_W-1:0]    served_number;
    logic                       queue_empty;

    modport source (output valid, output served_number, output queue_empty, input ready);
    modport sink   (input valid, input served_number, input queue_empty, output ready);
endinterface

// ===== rtl/tq_ram.sv =====
// simple dual-port synchronous ram with registered read data
module tq_ram #(
    parameter int WIDTH = tq_pkg::SN_W,
    parameter int DEPTH = tq_pkg::CAPACITY_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data registered when i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tq_ctrl.sv =====
// control: sequences the reads and write-backs of the slot and group tables
module tq_ctrl #(
    parameter int CAPACITY = tq_pkg::CAPACITY_DEF,
    parameter int GROUPS   = tq_pkg::GROUPS_DEF,
    localparam int SW      = $clog2(CAPACITY),
    localparam int LW      = SW + 1,
    localparam int GW      = $clog2(GROUPS),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tq_in_if.sink                    i_in,
    tq_out_if.source                 o_out,
    input  logic [tq_pkg::LIM_W-1:0] i_limit,
    // slot table: {group, link}
    output logic                     o_slot_we,
    output logic [SW-1:0]            o_slot_waddr,
    output logic [GW+LW-1:0]         o_slot_wdata,
    output logic                     o_slot_re,
    output logic [SW-1:0]            o_slot_raddr,
    input  logic [GW+LW-1:0]         i_slot_rdata,
    // group table: {valid, tail slot}
    output logic                     o_grp_we,
    output logic [GW-1:0]            o_grp_waddr,
    output logic [LW-1:0]            o_grp_wdata,
    output logic                     o_grp_re,
    output logic [GW-1:0]            o_grp_raddr,
    input  logic [LW-1:0]            i_grp_rdata
);

    localparam int         GID_N = 2 ** tq_pkg::GID_W;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ_GRP,
        S_ENQ_LINK,
        S_ENQ_FIN,
        S_DEQ_SLOT,
        S_DEQ_GRP,
        S_PUSH
    } t_state;

    t_state                    r_state, n_state;
    logic [GW-1:0]             r_clr_addr, n_clr_addr;
    logic [LW-1:0]             r_head, n_head;
    logic [LW-1:0]             r_tail, n_tail;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [GW-1:0]             r_gid, n_gid;
    logic [SW-1:0]             r_after, n_after;
    logic [LW-1:0]             r_link, n_link;
    logic [tq_pkg::SN_W-1:0]   r_res_served, n_res_served;
    logic                      r_res_empty, n_res_empty;
    logic                      r_out_valid, n_out_valid;
    logic [tq_pkg::SN_W-1:0]   r_out_served, n_out_served;
    logic                      r_out_empty, n_out_empty;

    logic [GW-1:0]             w_gmod [GID_N];
    logic                      w_room;
    logic [SW-1:0]             w_slot;
    logic [GW-1:0]             w_rd_group;
    logic [LW-1:0]             w_rd_link;
    logic                      w_grp_valid;
    logic [SW-1:0]             w_grp_idx;

    // group id folded into the table range
    for (genvar gi = 0; gi < GID_N; gi++) begin : g_gmod
        assign w_gmod[gi] = GW'(gi % GROUPS);
    end

    assign w_room      = (r_count < CNT_W'(CAPACITY))
                         && ({{tq_pkg::LIM_W{1'b0}}, r_count}
                             < {{CNT_W{1'b0}}, i_limit});
    assign w_slot      = r_count[SW-1:0];
    assign w_rd_group  = i_slot_rdata[LW +: GW];
    assign w_rd_link   = i_slot_rdata[LW-1:0];
    assign w_grp_valid = i_grp_rdata[SW];
    assign w_grp_idx   = i_grp_rdata[SW-1:0];

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.served_number = r_out_served;
    assign o_out.queue_empty   = r_out_empty;

    // next state, memory accesses
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_gid        = r_gid;
        n_after      = r_after;
        n_link       = r_link;
        n_res_served = r_res_served;
        n_res_empty  = r_res_empty;
        n_out_valid  = r_out_valid;
        n_out_served = r_out_served;
        n_out_empty  = r_out_empty;

        o_slot_we    = 1'b0;
        o_slot_waddr = w_slot;
        o_slot_wdata = {r_gid, r_link};
        o_slot_re    = 1'b0;
        o_slot_raddr = r_head[SW-1:0];
        o_grp_we     = 1'b0;
        o_grp_waddr  = r_gid;
        o_grp_wdata  = {1'b1, w_slot};
        o_grp_re     = 1'b0;
        o_grp_raddr  = w_gmod[i_in.group_id];

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // sweep the group table clear after reset
            S_CLEAR: begin
                o_grp_we    = 1'b1;
                o_grp_waddr = r_clr_addr;
                o_grp_wdata = '0;
                n_clr_addr  = GW'(r_clr_addr + GW'(1));
                if (r_clr_addr == GW'(GROUPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a request and issue its first read
            S_IDLE: begin
                if (i_in.valid) begin
                    n_gid = w_gmod[i_in.group_id];
                    if (i_in.opcode == tq_pkg::OP_ENQ) begin
                        o_grp_re = 1'b1;
                        n_state  = S_ENQ_GRP;
                    end else begin
                        o_slot_re = 1'b1;
                        n_state   = S_DEQ_SLOT;
                    end
                end
            end
            // group tail known: drop without room, start an empty queue, else pick the insertion point
            S_ENQ_GRP: begin
                if (!w_room) begin
                    n_state = S_IDLE;
                end else if (r_head == NIL) begin
                    o_slot_we    = 1'b1;
                    o_slot_wdata = {r_gid, NIL};
                    o_grp_we     = 1'b1;
                    n_head       = LW'(w_slot);
                    n_tail       = LW'(w_slot);
                    n_count      = CNT_W'(r_count + CNT_W'(1));
                    n_state      = S_IDLE;
                end else begin
                    n_after      = w_grp_valid ? w_grp_idx : r_tail[SW-1:0];
                    o_slot_re    = 1'b1;
                    o_slot_raddr = w_grp_valid ? w_grp_idx : r_tail[SW-1:0];
                    n_state      = S_ENQ_LINK;
                end
            end
            // point the predecessor at the new slot
            S_ENQ_LINK: begin
                o_slot_we    = 1'b1;
                o_slot_waddr = r_after;
                o_slot_wdata = {w_rd_group, LW'(w_slot)};
                n_link       = w_rd_link;
                n_state      = S_ENQ_FIN;
            end
            // write the new slot and the group tail
            S_ENQ_FIN: begin
                o_slot_we = 1'b1;
                o_grp_we  = 1'b1;
                if (r_link == NIL) begin
                    n_tail = LW'(w_slot);
                end
                n_count = CNT_W'(r_count + CNT_W'(1));
                n_state = S_IDLE;
            end
            // head slot read back: report an empty queue, or fetch its group tail
            S_DEQ_SLOT: begin
                if (r_head == NIL) begin
                    n_res_served = '0;
                    n_res_empty  = 1'b1;
                    n_state      = S_PUSH;
                end else begin
                    n_gid       = w_rd_group;
                    n_link      = w_rd_link;
                    o_grp_re    = 1'b1;
                    o_grp_raddr = w_rd_group;
                    n_state     = S_DEQ_GRP;
                end
            end
            // retire the head, drop the group tail if it was the head
            S_DEQ_GRP: begin
                if (w_grp_valid && (w_grp_idx == r_head[SW-1:0])) begin
                    o_grp_we    = 1'b1;
                    o_grp_wdata = {1'b0, w_grp_idx};
                end
                n_res_served = tq_pkg::SN_W'(LW'(r_head + LW'(1)));
                n_res_empty  = 1'b0;
                n_head       = r_link;
                if (r_link == NIL) begin
                    n_head = NIL;
                    n_tail = NIL;
                end
                n_state = S_PUSH;
            end
            // hand the result to the output register
            S_PUSH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_served = r_res_served;
                    n_out_empty  = r_res_empty;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_gid        <= n_gid;
        r_after      <= n_after;
        r_link       <= n_link;
        r_res_served <= n_res_served;
        r_res_empty  <= n_res_empty;
        r_out_served <= n_out_served;
        r_out_empty  <= n_out_empty;
    end

endmodule

// ===== rtl/team_queue_top.sv =====
// top level: team queue with apb limit register, control and two tables
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        opcode, group_id
//  o_out     out  valid/ready        served_number, queue_empty
//  apb       in   psel/penable       paddr, pwdata, prdata (arrival_limit at 0x0)
//
// an enqueue reads the group tail, links the predecessor, then writes the new slot
// and group tail (at once on an empty queue, never when dropped); a dequeue reads
// the head slot, then its group tail unless the queue is empty. after reset the
// group table is cleared while no request is taken. a result waits in the output
// register while the next request is taken; a dequeue meeting a full one holds.
module team_queue_top #(
    parameter int CAPACITY = tq_pkg::CAPACITY_DEF,
    parameter int GROUPS   = tq_pkg::GROUPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tq_in_if.sink                     i_in,
    tq_out_if.source                  o_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tq_pkg::APB_AW-1:0] paddr,
    input  logic [tq_pkg::APB_DW-1:0] pwdata,
    output logic [tq_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);

    localparam int SW = $clog2(CAPACITY);
    localparam int LW = SW + 1;
    localparam int GW = $clog2(GROUPS);

    logic [tq_pkg::LIM_W-1:0] r_limit;
    logic                     w_reg_hit;

    logic                     w_slot_we;
    logic [SW-1:0]            w_slot_waddr;
    logic [GW+LW-1:0]         w_slot_wdata;
    logic                     w_slot_re;
    logic [SW-1:0]            w_slot_raddr;
    logic [GW+LW-1:0]         w_slot_rdata;
    logic                     w_grp_we;
    logic [GW-1:0]            w_grp_waddr;
    logic [LW-1:0]            w_grp_wdata;
    logic                     w_grp_re;
    logic [GW-1:0]            w_grp_raddr;
    logic [LW-1:0]            w_grp_rdata;

    // apb register access
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == tq_pkg::REG_ARRIVAL_LIMIT);
    assign prdata    = w_reg_hit ? tq_pkg::APB_DW'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tq_pkg::LIMIT_RST;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_limit <= pwdata[tq_pkg::LIM_W-1:0];
        end
    end

    // sequencer
    tq_ctrl #(
        .CAPACITY (CAPACITY),
        .GROUPS   (GROUPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_limit      (r_limit),
        .o_slot_we    (w_slot_we),
        .o_slot_waddr (w_slot_waddr),
        .o_slot_wdata (w_slot_wdata),
        .o_slot_re    (w_slot_re),
        .o_slot_raddr (w_slot_raddr),
        .i_slot_rdata (w_slot_rdata),
        .o_grp_we     (w_grp_we),
        .o_grp_waddr  (w_grp_waddr),
        .o_grp_wdata  (w_grp_wdata),
        .o_grp_re     (w_grp_re),
        .o_grp_raddr  (w_grp_raddr),
        .i_grp_rdata  (w_grp_rdata)
    );

    // slot table: group and next link of each arrival
    tq_ram #(
        .WIDTH (GW + LW),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    // group table: valid flag and last queued slot of each group
    tq_ram #(
        .WIDTH (LW),
        .DEPTH (GROUPS)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (w_grp_we),
        .i_waddr (w_grp_waddr),
        .i_wdata (w_grp_wdata),
        .i_re    (w_grp_re),
        .i_raddr (w_grp_raddr),
        .o_rdata (w_grp_rdata)
    );

endmodule
